/* rtl/core/bpe_pkg.sv */
// shared types, constants and sizes of the boolean postfix evaluator
package bpe_pkg;

	localparam int STACK_DEPTH = 64;
	// top entries of the stack held in flops
	localparam int WIN_DEPTH = 4;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int WIN_W = $clog2(WIN_DEPTH + 1);
	localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
	localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

	localparam int CHAR_W = 8;
	localparam int MASK_W = 26;
	localparam int DEPTH_OUT_W = 7;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'd1;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NOT = 8'h21;
	localparam logic [CHAR_W-1:0] CH_AND = 8'h26;
	localparam logic [CHAR_W-1:0] CH_XOR = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_IMPL = 8'h3E;
	localparam logic [CHAR_W-1:0] CH_OR = 8'h7C;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

	// value of a pop from an empty stack, the '$' marker
	localparam logic EMPTY_POP_VAL = 1'b1;

	typedef enum logic [2:0] {
		OP_SKIP,
		OP_PUSH,
		OP_NOT,
		OP_BIN,
		OP_DROP2
	} op_kind_t;

	typedef enum logic [1:0] {
		FN_IMPL,
		FN_OR,
		FN_AND,
		FN_XOR
	} bin_fn_t;

	typedef struct packed {
		op_kind_t kind;
		bin_fn_t  fn;
		logic     lit;
	} tok_op_t;

	typedef struct packed {
		logic    fire;
		logic    last;
		tok_op_t op;
	} exec_req_t;

	typedef struct packed {
		logic                   truth;
		logic                   uf;
		logic                   ovf;
		logic [DEPTH_OUT_W-1:0] depth;
	} res_t;

endpackage

/* rtl/core/bpe_ram.sv */
// generic single write port ram with registered read
module bpe_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/bpe_decode.sv */
// character classifier: turns one token into a stack operation
module bpe_decode
	import bpe_pkg::*;
(
	input  logic [CHAR_W-1:0] token_char,
	input  logic [MASK_W-1:0] lower_vals,
	input  logic [MASK_W-1:0] upper_vals,
	output tok_op_t           op
);

	logic [CHAR_W-1:0] lower_off;
	logic [CHAR_W-1:0] upper_off;

	assign lower_off = token_char - CH_LOWER_A;
	assign upper_off = token_char - CH_UPPER_A;

	always_comb begin
		op.kind = OP_DROP2;
		op.fn = FN_IMPL;
		op.lit = 1'b0;
		unique case (token_char) inside
			CH_SPACE: op.kind = OP_SKIP;
			CH_NOT: op.kind = OP_NOT;
			[CH_LOWER_A:CH_LOWER_Z]: begin
				op.kind = OP_PUSH;
				op.lit = lower_vals[lower_off[4:0]];
			end
			[CH_UPPER_A:CH_UPPER_Z]: begin
				op.kind = OP_PUSH;
				op.lit = upper_vals[upper_off[4:0]];
			end
			CH_IMPL: begin
				op.kind = OP_BIN;
				op.fn = FN_IMPL;
			end
			CH_OR: begin
				op.kind = OP_BIN;
				op.fn = FN_OR;
			end
			CH_AND: begin
				op.kind = OP_BIN;
				op.fn = FN_AND;
			end
			CH_XOR: begin
				op.kind = OP_BIN;
				op.fn = FN_XOR;
			end
			// anything else pops two and pushes nothing
			default: op.kind = OP_DROP2;
		endcase
	end

endmodule

/* rtl/core/bpe_stack.sv */
// value stack: ram holds every entry, flops cache the top few, refilled from ram
module bpe_stack
	import bpe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  exec_req_t req,
	output logic      can_exec,
	output res_t      res
);

	logic [WIN_DEPTH-1:0] win_q;
	logic [WIN_W-1:0]     v_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 uf_q;
	logic                 ovf_q;
	logic                 rd_pend_q;

	logic [WIN_DEPTH-1:0] winm;
	logic [WIN_W-1:0]     vm;
	logic [WIN_W-1:0]     need;
	logic [1:0]           drop;
	logic                 uf_op;
	logic                 ovf_op;
	logic                 push_en;
	logic                 push_val;
	logic                 r0;
	logic                 r1;
	logic [WIN_DEPTH-1:0] win_d;
	logic [WIN_W-1:0]     v_d;
	logic [CNT_W-1:0]     cnt_d;
	logic [WIN_DEPTH-1:0] win_p;
	logic [WIN_W-1:0]     v_p;
	logic [CNT_W-1:0]     cnt_p;
	logic [CNT_W-1:0]     cnt_f;
	logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;

	logic [WIN_DEPTH-1:0] win_n;
	logic [WIN_W-1:0]     v_n;
	logic [CNT_W-1:0]     cnt_n;
	logic                 uf_n;
	logic                 ovf_n;

	logic                 rd_en;
	logic [CNT_W-1:0]     rd_idx;
	logic                 rd_data;

	// merge the refill beat that lands below the cached window
	always_comb begin
		winm = win_q;
		vm = v_q;
		if (rd_pend_q) begin
			winm[v_q[WIN_IDX_W-1:0]] = rd_data;
			vm = WIN_W'(v_q + WIN_W'(1));
		end
	end

	always_comb begin
		need = '0;
		case (req.op.kind)
			OP_SKIP, OP_PUSH: need = WIN_W'(req.last);
			OP_NOT: need = WIN_W'(1);
			OP_BIN: need = WIN_W'(2);
			OP_DROP2: need = req.last ? WIN_W'(3) : WIN_W'(2);
			default: need = WIN_W'(3);
		endcase
	end

	// everything cached or enough cached for the pops of this token
	assign can_exec = (CMP_W'(vm) >= CMP_W'(need)) || (CMP_W'(vm) == CMP_W'(cnt_q));

	assign r0 = (cnt_q >= CNT_W'(1)) ? winm[0] : EMPTY_POP_VAL;
	assign r1 = (cnt_q >= CNT_W'(2)) ? winm[1] : EMPTY_POP_VAL;

	always_comb begin
		drop = 2'd0;
		uf_op = 1'b0;
		ovf_op = 1'b0;
		push_en = 1'b0;
		push_val = 1'b0;
		case (req.op.kind)
			OP_PUSH: begin
				ovf_op = (cnt_q == CNT_W'(STACK_DEPTH));
				push_en = !ovf_op;
				push_val = req.op.lit;
			end
			OP_NOT: begin
				drop = (cnt_q != '0) ? 2'd1 : 2'd0;
				uf_op = (cnt_q == '0);
				push_en = 1'b1;
				push_val = ~r0;
			end
			OP_BIN, OP_DROP2: begin
				drop = (cnt_q >= CNT_W'(2)) ? 2'd2 : 2'(cnt_q);
				uf_op = (cnt_q < CNT_W'(2));
				push_en = (req.op.kind == OP_BIN);
				case (req.op.fn)
					FN_IMPL: push_val = ~r1 | r0;
					FN_OR: push_val = r1 | r0;
					FN_AND: push_val = r1 & r0;
					FN_XOR: push_val = r1 ^ r0;
					default: push_val = 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		win_d = winm >> drop;
		v_d = WIN_W'(vm - WIN_W'(drop));
		cnt_d = CNT_W'(cnt_q - CNT_W'(drop));
		win_p = win_d;
		v_p = v_d;
		cnt_p = cnt_d;
		if (push_en) begin
			win_p = {win_d[WIN_DEPTH-2:0], push_val};
			v_p = (v_d == WIN_W'(WIN_DEPTH)) ? v_d : WIN_W'(v_d + WIN_W'(1));
			cnt_p = CNT_W'(cnt_d + CNT_W'(1));
		end
	end

	// final pop on the last character
	always_comb begin
		cnt_f = (cnt_p != '0) ? CNT_W'(cnt_p - CNT_W'(1)) : cnt_p;
		depth_ext = {{DEPTH_OUT_W{1'b0}}, cnt_f};
		res.truth = (cnt_p != '0) ? win_p[0] : EMPTY_POP_VAL;
		res.uf = uf_q | uf_op | (cnt_p == '0);
		res.ovf = ovf_q | ovf_op;
		res.depth = depth_ext[DEPTH_OUT_W-1:0];
	end

	always_comb begin
		win_n = winm;
		v_n = vm;
		cnt_n = cnt_q;
		uf_n = uf_q;
		ovf_n = ovf_q;
		if (req.fire) begin
			if (req.last) begin
				v_n = '0;
				cnt_n = '0;
				uf_n = 1'b0;
				ovf_n = 1'b0;
			end else begin
				win_n = win_p;
				v_n = v_p;
				cnt_n = cnt_p;
				uf_n = uf_q | uf_op;
				ovf_n = ovf_q | ovf_op;
			end
		end
	end

	// fetch the entry just below the next window
	assign rd_en = (v_n < WIN_W'(WIN_DEPTH)) && (CMP_W'(cnt_n) > CMP_W'(v_n));
	assign rd_idx = CNT_W'(cnt_n - CNT_W'(v_n) - CNT_W'(1));

	bpe_ram #(
		.WIDTH(1),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (req.fire && push_en && !req.last),
		.wr_addr (cnt_d[ADDR_W-1:0]),
		.wr_data (push_val),
		.rd_en   (rd_en),
		.rd_addr (rd_idx[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			cnt_q <= '0;
			uf_q <= 1'b0;
			ovf_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			v_q <= v_n;
			cnt_q <= cnt_n;
			uf_q <= uf_n;
			ovf_q <= ovf_n;
			rd_pend_q <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_n;
	end

`ifndef SYNTHESIS
	a_win_within_stack: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(v_q) <= CMP_W'(cnt_q))
		else $error("cached window deeper than stack");
	a_refill_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (v_q < WIN_W'(WIN_DEPTH)))
		else $error("refill beat with full window");
	a_fire_needs_operands: assert property (@(posedge clk) disable iff (!arst_n)
		req.fire |-> can_exec)
		else $error("token executed without cached operands");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(req.fire && req.last) |=> (cnt_q == '0 && v_q == '0 && !uf_q && !ovf_q))
		else $error("stack not cleared after last character");
`endif

endmodule

/* rtl/core/boolean_postfix_evaluator_unit.sv */
// top level of the boolean postfix evaluator: config regs, input and output stages
// usage:
//   cfg channel: cfg_index 0 writes the truth values of a..z, 1 those of A..Z
//     (bit 0 is a / A); always ready, write only while the stream is idle
//   s_axis: one character per beat in tdata, tlast marks the last character
//   m_axis: one beat per expression, sent for the beat that carried tlast
//   a character is registered at the input and executed once its operands are
//     cached; the result of the last one is registered and shown on m_axis
//   throughput is one character per cycle while the operands are cached; the top
//     four stack entries sit in flops, the rest in a ram with a write and a read
//     port that refills one entry a cycle, so a token that pops more than is cached
//     waits for refills (e.g. back-to-back tokens that pop two and push nothing)
//   reset empties the stack, clears the error flags and both letter masks;
//     the ram needs no clearing pass
//   while m_axis is stalled with a result held, characters of the next
//     expression keep flowing until its own last character needs the
//     output register
module boolean_postfix_evaluator_unit
	import bpe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [CHAR_W-1:0]     s_axis_tdata,  // [7:0] token_char
	input  logic                  s_axis_tlast,  // end_of_expr
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [0] truth_value, [1] underflow_seen,
	                                             // [2] overflow_seen, [9:3] depth_left
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [MASK_W-1:0]     cfg_data
);

	logic [MASK_W-1:0] lower_q;
	logic [MASK_W-1:0] upper_q;

	tok_op_t   dec_op;
	logic      valid_s1;
	tok_op_t   op_s1;
	logic      last_s1;
	logic      can_exec;
	logic      out_free;
	logic      fire;
	exec_req_t req;
	res_t      res;
	logic      m_valid_q;
	res_t      res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOWER: lower_q <= cfg_data;
				CFG_UPPER: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bpe_decode u_decode (
		.token_char (s_axis_tdata),
		.lower_vals (lower_q),
		.upper_vals (upper_q),
		.op         (dec_op)
	);

	assign out_free = !m_valid_q || m_axis_tready;
	assign fire = valid_s1 && can_exec && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1 <= dec_op;
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		req.fire = fire;
		req.last = last_s1;
		req.op = op_s1;
	end

	bpe_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.can_exec (can_exec),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {{(OUT_DATA_W - DEPTH_OUT_W - 3){1'b0}},
		res_q.depth, res_q.ovf, res_q.uf, res_q.truth};

endmodule
